FILE: rtl/amre_pkg.sv
package amre_pkg;

    // Map geometry and literal buffer sizing
    localparam int ROW_WIDTH = 64;
    localparam int BUF_DEPTH = 64;
    localparam int LIT_CAP   = (ROW_WIDTH <= 64) ? 64 : 63;
    localparam int MAX_RUN   = 127;

    localparam int COL_W     = $clog2(ROW_WIDTH);
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;

    // Literal RAM holds two banks: one filling, one draining
    localparam int RAM_DEPTH = 2 * BUF_DEPTH;
    localparam int ADDR_W    = IDX_W + 1;

    // Command queue between front and back
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef struct packed {
        logic [BYTE_W-1:0] alpha_byte;
        logic              end_of_map;
    } t_in;

    typedef struct packed {
        logic              entry_start;
        logic              fill_mode;
        logic [CNT_W-1:0]  entry_count;
        logic [BYTE_W-1:0] value;
        logic              last_of_burst;
    } t_out;

    // One queued command: optional copy entry, then optional fill entry
    typedef struct packed {
        logic              has_copy;
        logic              copy_bank;
        logic [CNT_W-1:0]  copy_n;
        logic              has_fill;
        logic [CNT_W-1:0]  fill_n;
        logic [BYTE_W-1:0] fill_val;
        logic              last;
    } t_cmd;

    // Bank release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    // Literal write from front to RAM
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

endpackage

FILE: rtl/amre_ram.sv
module amre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/amre_fifo.sv
module amre_fifo
    import amre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_rdata
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

endmodule

FILE: rtl/amre_front.sv
module amre_front
    import amre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full,
    output t_wr  o_wr,
    input  t_rel i_rel
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CHG,
        F_ROW
    } t_fstate;

    t_fstate           r_state, n_state;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_row_end, n_row_end;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_run_open, n_run_open;
    logic [BYTE_W-1:0] r_run_val, n_run_val;
    logic [CNT_W-1:0]  r_run_len, n_run_len;
    logic [CNT_W-1:0]  r_lit_cnt, n_lit_cnt;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;

    logic              fill_close;
    logic [CNT_W-1:0]  lit_plus;
    logic              need_write;
    logic              flush_all;
    logic              cl_ok;
    t_cmd              cl_cmd;
    logic              do_push;
    logic              do_write;

    // Actions for closing the open run; a row end also flushes every literal
    always_comb begin
        flush_all  = (r_state == F_ROW);
        fill_close = (r_run_len >= CNT_W'(2));
        lit_plus   = r_lit_cnt + 1'b1;

        cl_cmd           = '0;
        cl_cmd.copy_bank = r_bank;
        cl_cmd.fill_n    = r_run_len;
        cl_cmd.fill_val  = r_run_val;
        cl_cmd.last      = flush_all || !r_row_end;
        if (fill_close) begin
            need_write      = 1'b0;
            cl_cmd.has_fill = 1'b1;
            cl_cmd.has_copy = (r_lit_cnt != '0);
            cl_cmd.copy_n   = r_lit_cnt;
        end else begin
            need_write      = 1'b1;
            cl_cmd.has_fill = 1'b0;
            cl_cmd.has_copy = flush_all || (lit_plus >= CNT_W'(LIT_CAP));
            cl_cmd.copy_n   = lit_plus;
        end
        cl_ok = !i_full && !(need_write && r_busy[r_bank]);
    end

    // Item sequencing: accept, close on value change, close at row end
    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_row_end  = r_row_end;
        n_col      = r_col;
        n_run_open = r_run_open;
        n_run_val  = r_run_val;
        n_run_len  = r_run_len;
        n_lit_cnt  = r_lit_cnt;
        n_bank     = r_bank;
        n_busy     = r_busy;
        do_push    = 1'b0;
        do_write   = 1'b0;

        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_byte    = i_data.alpha_byte;
                    n_row_end = i_data.end_of_map || (r_col >= COL_W'(ROW_WIDTH - 1));
                    n_col     = n_row_end ? '0 : r_col + 1'b1;
                    n_state   = F_CHG;
                end
            end
            F_CHG: begin
                if (r_run_open && (r_byte == r_run_val) && (r_run_len < CNT_W'(MAX_RUN))) begin
                    n_run_len = r_run_len + 1'b1;
                    n_state   = r_row_end ? F_ROW : F_IDLE;
                end else if (!r_run_open || cl_ok) begin
                    if (r_run_open) begin
                        do_write = need_write;
                        do_push  = cl_cmd.has_copy || cl_cmd.has_fill;
                        if (cl_cmd.has_copy) begin
                            n_lit_cnt      = '0;
                            n_bank         = ~r_bank;
                            n_busy[r_bank] = 1'b1;
                        end else if (need_write) begin
                            n_lit_cnt = lit_plus;
                        end
                    end
                    n_run_open = 1'b1;
                    n_run_val  = r_byte;
                    n_run_len  = CNT_W'(1);
                    n_state    = r_row_end ? F_ROW : F_IDLE;
                end
            end
            F_ROW: begin
                if (cl_ok) begin
                    do_write   = need_write;
                    do_push    = 1'b1;
                    n_lit_cnt  = '0;
                    n_run_open = 1'b0;
                    n_run_len  = '0;
                    if (cl_cmd.has_copy) begin
                        n_bank         = ~r_bank;
                        n_busy[r_bank] = 1'b1;
                    end
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // State and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_row_end  <= 1'b0;
            r_col      <= '0;
            r_run_open <= 1'b0;
            r_run_val  <= '0;
            r_run_len  <= '0;
            r_lit_cnt  <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_state    <= n_state;
            r_row_end  <= n_row_end;
            r_col      <= n_col;
            r_run_open <= n_run_open;
            r_run_val  <= n_run_val;
            r_run_len  <= n_run_len;
            r_lit_cnt  <= n_lit_cnt;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
        end
        r_byte <= n_byte;
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = do_push;
    assign o_cmd   = cl_cmd;
    assign o_wr.en   = do_write;
    assign o_wr.addr = {r_bank, r_lit_cnt[IDX_W-1:0]};
    assign o_wr.data = r_run_val;

endmodule

FILE: rtl/amre_back.sv
module amre_back
    import amre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output t_rel              o_rel,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_valid,
    output t_out              o_data,
    input  logic              i_stall
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_COPY,
        B_FILL
    } t_bstate;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    t_out             r_pmeta, n_pmeta;
    logic             r_puse_ram, n_puse_ram;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic can_load;
    logic load;
    logic slot_free;
    logic last_idx;

    // Output register takes the pending item when free or being drained
    always_comb begin
        can_load  = !r_out_valid || !i_stall;
        load      = r_pend && can_load;
        slot_free = !r_pend || load;
        last_idx  = ((CNT_W'(r_idx) + 1'b1) == r_cmd.copy_n);
    end

    // Entry sequencing: copy items read from RAM, then the fill item
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_pend      = r_pend && !load;
        n_pmeta     = r_pmeta;
        n_puse_ram  = r_puse_ram;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        o_rel       = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = {r_cmd.copy_bank, r_idx};

        if (load) begin
            n_out_valid = 1'b1;
            n_out       = r_pmeta;
            n_out.value = r_puse_ram ? i_rd_data : r_pmeta.value;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_state = i_cmd.has_copy ? B_COPY : B_FILL;
                end
            end
            B_COPY: begin
                if (slot_free) begin
                    o_rd_en                = 1'b1;
                    n_pend                 = 1'b1;
                    n_puse_ram             = 1'b1;
                    n_pmeta.entry_start    = (r_idx == '0);
                    n_pmeta.fill_mode      = 1'b0;
                    n_pmeta.entry_count    = r_cmd.copy_n;
                    n_pmeta.value          = '0;
                    n_pmeta.last_of_burst  = r_cmd.last && !r_cmd.has_fill && last_idx;
                    n_idx                  = r_idx + 1'b1;
                    if (last_idx) begin
                        o_rel.valid = 1'b1;
                        o_rel.bank  = r_cmd.copy_bank;
                        n_state     = r_cmd.has_fill ? B_FILL : B_IDLE;
                    end
                end
            end
            B_FILL: begin
                if (slot_free) begin
                    n_pend                = 1'b1;
                    n_puse_ram            = 1'b0;
                    n_pmeta.entry_start   = 1'b1;
                    n_pmeta.fill_mode     = 1'b1;
                    n_pmeta.entry_count   = r_cmd.fill_n;
                    n_pmeta.value         = r_cmd.fill_val;
                    n_pmeta.last_of_burst = r_cmd.last;
                    n_state               = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_pmeta    <= n_pmeta;
        r_puse_ram <= n_puse_ram;
        r_out      <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/alpha_map_rle_encoder.sv
// Results pass from the front through the command queue and, for copies, the literal
// RAM to the back, which holds each in its pending slot and then its output register.
// The front takes a new item only once it has checked the last for a value change and,
// at a row or map end, flushed; it waits when the command queue is full or the literal
// bank it fills is still being read out.
// The back sends one result per cycle unless stalled, with an idle state per command.
// Synchronous active-low reset clears all control.
module alpha_map_rle_encoder
    import amre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    t_wr               lit_wr;
    t_rel              rel;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Front: run tracking and literal collection
    amre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full),
        .o_wr    (lit_wr),
        .i_rel   (rel)
    );

    // Command queue
    amre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (head_cmd)
    );

    // Two-bank literal buffer
    amre_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (lit_wr.en),
        .i_waddr (lit_wr.addr),
        .i_wdata (lit_wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Back: entry emission
    amre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_rel     (rel),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

FILE: rtl/amre_checker.sv
module amre_checker
    import amre_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // An accepted item keeps the input stalled for at least the next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted on back-to-back cycles");

    // Fill entries are one item with a header
    a_fill_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.fill_mode |-> o_data.entry_start && (o_data.entry_count >= 7'd2))
        else $error("malformed fill entry");

    // Copy entries hold between one and sixty-four literals
    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.fill_mode |-> (o_data.entry_count != 7'd0)
                                         && (o_data.entry_count <= 7'd64))
        else $error("copy count out of range");

    // A continuation item is always a literal
    a_cont_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.entry_start |-> !o_data.fill_mode)
        else $error("continuation item in fill mode");

endmodule

bind alpha_map_rle_encoder amre_checker u_amre_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
